// File: sv/dmm_pkg.sv
// Shared types and constants for the dense matrix multiply block.
// Used by dmm_mac and dense_matrix_multiply; depends on nothing else.

package dmm_pkg;

	// Fixed field widths of the ports.
	localparam int CMD_W     = 2;
	localparam int IDX_IN_W  = 4;
	localparam int ELEM_IN_W = 16;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W     = 40;
	localparam int COL_OUT_W = 4;

	// Accumulator width and saturation limits.
	localparam int ACC_W = 64;
	localparam logic signed [ACC_W-1:0] ACC_LIM     = 64'sh2000_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] ACC_LIM_NEG = -64'sh2000_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] OUT_MAX_ACC = 64'sh0000_007F_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] OUT_MIN_ACC = -64'sh0000_0080_0000_0000;

	// Reset value of every dimension register.
	localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

	// Command codes of an input transaction.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_LEFT  = 2'd0,
		CMD_LOAD_RIGHT = 2'd1,
		CMD_COMPUTE    = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_ROWS = 2'd0,
		CFG_X_COLS = 2'd1,
		CFG_W_ROWS = 2'd2,
		CFG_W_COLS = 2'd3
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Control that travels with one operand pair into the MAC unit.
	typedef struct packed {
		logic valid;
		logic first;
	} mac_ctrl_t;

endpackage

// File: sv/dense_matrix_multiply.sv
// Dense matrix multiply H = X * W with two element stores, a sequencer and one shared MAC.
// Depends on dmm_pkg and dmm_mac.
// A compute transaction works through the row one column at a time: one MAC step per cycle on
// the single multiplier, then the pipeline drains and the result of the column is emitted; an
// erroneous row emits its w_cols results without any MAC steps.
// Reset clears the sequencer and the output valid flag and sets all dimension registers to 16;
// the element stores and the output payload are not cleared.

module dense_matrix_multiply #(
	parameter int MAX_DIM    = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Command channel
	input  logic                                    cmd_valid,
	output logic                                    cmd_stall,
	input  logic [dmm_pkg::CMD_W-1:0]               command,
	input  logic [dmm_pkg::IDX_IN_W-1:0]            row_index,
	input  logic [dmm_pkg::IDX_IN_W-1:0]            col_index,
	input  logic signed [dmm_pkg::ELEM_IN_W-1:0]    element_value,
	// Result channel
	output logic                                    res_valid,
	input  logic                                    res_stall,
	output logic signed [dmm_pkg::OUT_W-1:0]        result_value,
	output logic [dmm_pkg::COL_OUT_W-1:0]           result_col,
	output logic                                    last_in_row,
	output logic                                    dim_error,
	// Configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [dmm_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [dmm_pkg::CFG_W-1:0]               cfg_data
);

	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W     = $clog2(MAX_DIM + 1);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	// Effective dimension: zero counts as one, anything above MAX_DIM counts as MAX_DIM.
	function automatic logic [CNT_W-1:0] eff_dim(input logic [dmm_pkg::CFG_W-1:0] v);
		logic [CNT_W-1:0] d;
		if (v == '0) begin
			d = CNT_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			d = CNT_W'(MAX_DIM);
		end else begin
			d = CNT_W'(v);
		end
		return d;
	endfunction

	// Configuration registers
	logic [dmm_pkg::CFG_W-1:0] x_rows_q, x_cols_q, w_rows_q, w_cols_q;

	// Sequencer
	dmm_pkg::state_t state_q, state_next;
	logic [IDX_W-1:0] row_q, j_q, k_q;
	logic [CNT_W-1:0] xc_q, wc_q;
	logic             err_q;

	// Element stores and read stage
	logic signed [ELEM_WIDTH-1:0] left_mem  [MEM_DEPTH];
	logic signed [ELEM_WIDTH-1:0] right_mem [MEM_DEPTH];
	logic signed [ELEM_WIDTH-1:0] left_rd_s1, right_rd_s1;
	dmm_pkg::mac_ctrl_t           mac_ctrl_s1;

	// Output register
	logic                             res_valid_q;
	logic signed [dmm_pkg::OUT_W-1:0] result_value_q;
	logic [dmm_pkg::COL_OUT_W-1:0]    result_col_q;
	logic                             last_in_row_q;
	logic                             dim_error_q;

	// Decoded controls
	logic                         cmd_fire, cfg_fire;
	logic                         load_in_range, load_left_we, load_right_we, compute_start;
	logic                         start_err;
	logic                         issue, emit_fire, last_k, last_col, mac_busy;
	logic [CNT_W-1:0]             xr_eff, xc_eff, wr_eff, wc_eff;
	logic [ADDR_W-1:0]            waddr, left_raddr, right_raddr;
	logic signed [ELEM_WIDTH-1:0] elem_w;
	logic signed [dmm_pkg::OUT_W-1:0] mac_result;

	assign cmd_fire = cmd_valid && !cmd_stall;
	assign cfg_fire = cfg_valid && cfg_ready;

	assign xr_eff = eff_dim(x_rows_q);
	assign xc_eff = eff_dim(x_cols_q);
	assign wr_eff = eff_dim(w_rows_q);
	assign wc_eff = eff_dim(w_cols_q);

	// Command decode for the transaction at the input.
	always_comb begin
		load_left_we  = 1'b0;
		load_right_we = 1'b0;
		compute_start = 1'b0;
		load_in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
		unique case (command)
			dmm_pkg::CMD_LOAD_LEFT:  load_left_we  = cmd_fire && load_in_range;
			dmm_pkg::CMD_LOAD_RIGHT: load_right_we = cmd_fire && load_in_range;
			dmm_pkg::CMD_COMPUTE:    compute_start = cmd_fire;
			default:                 compute_start = 1'b0;
		endcase
	end

	assign start_err = (xc_eff != wr_eff) || (32'(row_index) >= 32'(xr_eff));
	assign elem_w    = ELEM_WIDTH'(element_value);
	assign waddr     = {IDX_W'(row_index), IDX_W'(col_index)};
	assign left_raddr  = {row_q, k_q};
	assign right_raddr = {k_q, j_q};

	assign last_k   = (CNT_W'(k_q) == xc_q - CNT_W'(1));
	assign last_col = (CNT_W'(j_q) == wc_q - CNT_W'(1));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_rows_q <= dmm_pkg::DIM_RESET;
			x_cols_q <= dmm_pkg::DIM_RESET;
			w_rows_q <= dmm_pkg::DIM_RESET;
			w_cols_q <= dmm_pkg::DIM_RESET;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				dmm_pkg::CFG_X_ROWS: x_rows_q <= cfg_data;
				dmm_pkg::CFG_X_COLS: x_cols_q <= cfg_data;
				dmm_pkg::CFG_W_ROWS: w_rows_q <= cfg_data;
				dmm_pkg::CFG_W_COLS: w_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			dmm_pkg::ST_IDLE: begin
				if (compute_start) begin
					state_next = start_err ? dmm_pkg::ST_EMIT : dmm_pkg::ST_MAC;
				end
			end
			dmm_pkg::ST_MAC: begin
				if (last_k) begin
					state_next = dmm_pkg::ST_DRAIN;
				end
			end
			dmm_pkg::ST_DRAIN: begin
				if (!mac_ctrl_s1.valid && !mac_busy) begin
					state_next = dmm_pkg::ST_EMIT;
				end
			end
			dmm_pkg::ST_EMIT: begin
				if (emit_fire) begin
					if (last_col) begin
						state_next = dmm_pkg::ST_IDLE;
					end else begin
						state_next = err_q ? dmm_pkg::ST_EMIT : dmm_pkg::ST_MAC;
					end
				end
			end
			default: state_next = dmm_pkg::ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		cmd_stall = (state_q != dmm_pkg::ST_IDLE);
		cfg_ready = (state_q == dmm_pkg::ST_IDLE);
		issue     = (state_q == dmm_pkg::ST_MAC);
		emit_fire = (state_q == dmm_pkg::ST_EMIT) && (!res_valid_q || !res_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Row, column and term counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			j_q   <= '0;
			k_q   <= '0;
			xc_q  <= '0;
			wc_q  <= '0;
			err_q <= 1'b0;
		end else if (compute_start) begin
			row_q <= IDX_W'(row_index);
			j_q   <= '0;
			k_q   <= '0;
			xc_q  <= xc_eff;
			wc_q  <= wc_eff;
			err_q <= start_err;
		end else if (emit_fire) begin
			j_q <= j_q + IDX_W'(1);
			k_q <= '0;
		end else if (issue) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	// Left store: loads write, the sequencer reads one element of row i per cycle.
	always_ff @(posedge clk) begin
		if (load_left_we) begin
			left_mem[waddr] <= elem_w;
		end
		left_rd_s1 <= left_mem[left_raddr];
	end

	// Right store: loads write, the sequencer reads one element of column j per cycle.
	always_ff @(posedge clk) begin
		if (load_right_we) begin
			right_mem[waddr] <= elem_w;
		end
		right_rd_s1 <= right_mem[right_raddr];
	end

	// Control that follows the read data into the MAC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_ctrl_s1 <= '0;
		end else begin
			mac_ctrl_s1.valid <= issue;
			mac_ctrl_s1.first <= (k_q == '0);
		end
	end

	dmm_mac #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s1 (mac_ctrl_s1),
		.a_s1    (left_rd_s1),
		.b_s1    (right_rd_s1),
		.busy    (mac_busy),
		.result  (mac_result)
	);

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register: payload of one result transaction.
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			result_value_q <= err_q ? '0 : mac_result;
			result_col_q   <= dmm_pkg::COL_OUT_W'(j_q);
			last_in_row_q  <= last_col;
			dim_error_q    <= err_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign result_value = result_value_q;
	assign result_col   = result_col_q;
	assign last_in_row  = last_in_row_q;
	assign dim_error    = dim_error_q;

	// An erroneous result always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && dim_error |-> result_value == '0)
		else $error("dim_error result with nonzero value");

	// A compute transaction makes the block busy in the next cycle.
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		compute_start |=> cmd_stall)
		else $error("block not busy after compute transaction");

	// The MAC pipeline is empty whenever the sequencer is idle.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dmm_pkg::ST_IDLE |-> !mac_ctrl_s1.valid && !mac_busy)
		else $error("MAC pipeline active while idle");

	// A result is produced only after the pipeline has drained.
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> !mac_ctrl_s1.valid && !mac_busy)
		else $error("result emitted with MAC terms in flight");

endmodule

// File: sv/dmm_mac.sv
// Shared multiply-accumulate unit: one registered multiplier and a saturating accumulator.
// Depends on dmm_pkg for the control struct and the saturation limits.

module dmm_mac #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dmm_pkg::mac_ctrl_t                  ctrl_s1,
	input  logic signed [ELEM_WIDTH-1:0]        a_s1,
	input  logic signed [ELEM_WIDTH-1:0]        b_s1,
	output logic                                busy,
	output logic signed [dmm_pkg::OUT_W-1:0]    result
);

	localparam int PROD_W = 2 * ELEM_WIDTH;

	dmm_pkg::mac_ctrl_t                   ctrl_s2;
	logic signed [PROD_W-1:0]             prod_s2;
	logic signed [dmm_pkg::ACC_W-1:0]     acc_q;
	logic signed [dmm_pkg::ACC_W-1:0]     acc_base;
	logic signed [dmm_pkg::ACC_W-1:0]     acc_sum;
	logic signed [dmm_pkg::ACC_W-1:0]     acc_next;

	// Control of the product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	// Registered multiplier.
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	// The first term of a dot product starts from zero; the running sum saturates.
	always_comb begin
		acc_base = ctrl_s2.first ? '0 : acc_q;
		acc_sum  = acc_base + dmm_pkg::ACC_W'(prod_s2);
		if (acc_sum > dmm_pkg::ACC_LIM) begin
			acc_next = dmm_pkg::ACC_LIM;
		end else if (acc_sum < dmm_pkg::ACC_LIM_NEG) begin
			acc_next = dmm_pkg::ACC_LIM_NEG;
		end else begin
			acc_next = acc_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			acc_q <= acc_next;
		end
	end

	// Final value clamped to the output range.
	always_comb begin
		if (acc_q > dmm_pkg::OUT_MAX_ACC) begin
			result = dmm_pkg::OUT_W'(dmm_pkg::OUT_MAX_ACC);
		end else if (acc_q < dmm_pkg::OUT_MIN_ACC) begin
			result = dmm_pkg::OUT_W'(dmm_pkg::OUT_MIN_ACC);
		end else begin
			result = dmm_pkg::OUT_W'(acc_q);
		end
	end

	assign busy = ctrl_s2.valid;

endmodule
